>>> design/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg
// shared types and constants of the windowed min / max / mean feature unit
// ----------------------------------------------------------------------------
package wmm_pkg;

    // fixed widths of the stream fields
    localparam int FIELD_W     = 16;
    localparam int LANES       = 3;
    localparam int ROW_OUT_W   = 8;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 160;

    // kind codes on the input tuser
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    // status codes on the output tuser
    localparam logic STATUS_VALID    = 1'b0;
    localparam logic STATUS_NOT_FULL = 1'b1;

    // per-cycle commands from the sequencer to every channel lane
    typedef struct packed {
        logic acc_en;      // read word valid, accumulate it
        logic acc_first;   // read word is entry zero, restart the sums
        logic div_load;    // latch sign and magnitude of the sum
        logic div_step;    // multiply the magnitude by the depth reciprocal
    } lane_ctrl_t;

endpackage

>>> design/wmm_ring.sv
// ----------------------------------------------------------------------------
// wmm_ring
// sample ring memory, per-channel write enables, one registered read port
// ----------------------------------------------------------------------------
module wmm_ring
    import wmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 120,
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_BITS  = 16,
    localparam int AW          = $clog2(WINDOW_DEPTH)
)
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [AW-1:0]                   wr_addr,
    input  logic [CHANNELS-1:0]             wr_lane_en,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [AW-1:0]                   rd_addr,
    output logic [CHANNELS*SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH][CHANNELS];
    logic [CHANNELS*SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (wr_en && wr_lane_en[c])
            begin
                mem[wr_addr][c] <= wr_data[c*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                rd_data_reg[c*SAMPLE_BITS +: SAMPLE_BITS] <= mem[rd_addr][c];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/wmm_lane.sv
// ----------------------------------------------------------------------------
// wmm_lane
// one channel: running sum, min and max over the scan, then the mean as a
// reciprocal multiply of the sum magnitude
// ----------------------------------------------------------------------------
module wmm_lane
    import wmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 120,
    parameter int SAMPLE_BITS  = 16,
    localparam int DW          = $clog2(WINDOW_DEPTH),
    localparam int ACC_W       = SAMPLE_BITS + DW + 1
)
(
    input  logic                          clk,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] mean,
    output logic signed [SAMPLE_BITS-1:0] max_val,
    output logic signed [SAMPLE_BITS-1:0] min_val
);

    // magnitude width of the sum; the reciprocal is rounded up so that
    // (mag * RECIP) >> RECIP_SHIFT is exactly mag / WINDOW_DEPTH
    localparam int     MAG_W       = ACC_W - 1;
    localparam int     RECIP_SHIFT = MAG_W + DW;
    localparam longint RECIP_L     =
        ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_DEPTH) - longint'(1))
        / longint'(WINDOW_DEPTH);
    localparam logic [MAG_W:0] RECIP = (MAG_W+1)'(RECIP_L);

    logic signed [ACC_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic                          neg_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [SAMPLE_BITS-1:0]        quo_reg;

    logic signed [ACC_W-1:0] sample_ext;
    logic [ACC_W-1:0]        mag;
    logic [2*MAG_W:0]        product;

    assign sample_ext = ACC_W'(sample);
    assign mag        = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : ACC_W'(sum_reg);
    assign product    = mag_reg * RECIP;

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            if (ctrl.acc_first)
            begin
                sum_reg <= sample_ext;
                min_reg <= sample;
                max_reg <= sample;
            end
            else
            begin
                sum_reg <= sum_reg + sample_ext;
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
            end
        end

        // magnitude never reaches the top bit of the sum
        if (ctrl.div_load)
        begin
            neg_reg <= sum_reg[ACC_W-1];
            mag_reg <= MAG_W'(mag);
        end
        else if (ctrl.div_step)
        begin
            quo_reg <= product[RECIP_SHIFT +: SAMPLE_BITS];
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign mean    = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
    assign max_val = max_reg;
    assign min_val = min_reg;

endmodule

>>> design/windowed_min_max_mean_features_unit.sv
// ----------------------------------------------------------------------------
// windowed_min_max_mean_features_unit
// sliding window min / max / mean features over three sensor channels
// ----------------------------------------------------------------------------
// usage:
//   input stream (s_*): s_tuser is the kind, 0 = sample word, 1 = compute word.
//   a sample word writes the leading channel_count channels of the ring entry
//   at the write pointer and advances it; it gives no output word. the window
//   is full once the pointer has wrapped.
//   a compute word gives one output word (m_*). with the window not full, the
//   sequencer goes straight to the finishing state, which raises m_tvalid
//   with m_tuser = 1 and all data zero and then takes the next word.
//   otherwise the ring is scanned one entry per cycle through the single
//   memory read port, then each mean is one reciprocal multiply: the states
//   run scan, tail, load, divide and finish, and m_tvalid rises as the finish
//   state hands over the result. s_tready is low during that work, so no
//   sample can touch the ring while it is being read.
//   after reset a clearing pass writes zero to every ring entry, one per
//   cycle, with s_tready low.
//   the result sits in an output register: a stalled receiver holds it while
//   sample words are still taken; a compute word waits for the register to
//   drain before it hands over its result, with s_tready low meanwhile.
// ----------------------------------------------------------------------------
module windowed_min_max_mean_features_unit
    import wmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 120,
    parameter int HISTORY_ROWS = 180,
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pack_voltage, cell_temperature, ambient_temperature, channel_count, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                 s_tuser,
    // output words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // voltage_mean, voltage_max, voltage_min, cell_temp_mean, cell_temp_max,
    // cell_temp_min, ambient_mean, ambient_max, ambient_min, feature_row,
    // history_full, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic                 m_tuser
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int ROW_W = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
    localparam int RW    = CHANNELS * SAMPLE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        cnt_reg, cnt_next;       // clear and scan address
    logic [AW-1:0]        wp_reg, wp_next;         // ring write pointer
    logic                 full_reg, full_next;     // window wrapped once
    logic [ROW_W-1:0]     row_reg, row_next;       // history row counter
    logic                 wrapped_reg, wrapped_next;
    logic                 nf_reg, nf_next;         // compute word on a partial window
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_first_reg, rd_first_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // ring port
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CHANNELS-1:0] wr_lane_en;
    logic [RW-1:0]       wr_data;
    logic [RW-1:0]       sample_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [RW-1:0]       rd_data;

    lane_ctrl_t          lane_ctrl;
    logic [1:0]          ch_count;
    logic [1:0]          ch_clamped;
    logic [CHANNELS-1:0] lane_mask;
    logic                s_accept;
    logic                history_flag;

    // features of all lanes, 16-bit fields
    logic [FIELD_W-1:0] f_mean [LANES];
    logic [FIELD_W-1:0] f_max  [LANES];
    logic [FIELD_W-1:0] f_min  [LANES];
    logic [M_TDATA_W-1:0] feature_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // sample fields into ring width, channels clamped to what is built
    assign ch_count   = s_tdata[LANES*FIELD_W +: 2];
    assign ch_clamped = (ch_count > 2'(CHANNELS)) ? 2'(CHANNELS) : ch_count;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sample_data[c*SAMPLE_BITS +: SAMPLE_BITS] =
                SAMPLE_BITS'(s_tdata[c*FIELD_W +: FIELD_W]);
            lane_mask[c] = (2'(c) < ch_clamped);
        end
    end

    wmm_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .CHANNELS     (CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ring (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_lane_en (wr_lane_en),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // one lane per built channel, unbuilt channels read as zero
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g < CHANNELS)
        begin : g_on
            logic signed [SAMPLE_BITS-1:0] l_mean;
            logic signed [SAMPLE_BITS-1:0] l_max;
            logic signed [SAMPLE_BITS-1:0] l_min;

            wmm_lane #(
                .WINDOW_DEPTH (WINDOW_DEPTH),
                .SAMPLE_BITS  (SAMPLE_BITS)
            ) u_lane (
                .clk     (clk),
                .ctrl    (lane_ctrl),
                .sample  (signed'(rd_data[g*SAMPLE_BITS +: SAMPLE_BITS])),
                .mean    (l_mean),
                .max_val (l_max),
                .min_val (l_min)
            );

            assign f_mean[g] = FIELD_W'(l_mean);
            assign f_max[g]  = FIELD_W'(l_max);
            assign f_min[g]  = FIELD_W'(l_min);
        end
        else
        begin : g_off
            assign f_mean[g] = '0;
            assign f_max[g]  = '0;
            assign f_min[g]  = '0;
        end
    end

    // scan results reach the lanes in the cycle after the read was issued
    always_comb
    begin
        lane_ctrl           = '0;
        lane_ctrl.acc_en    = rd_valid_reg;
        lane_ctrl.acc_first = rd_first_reg;
        lane_ctrl.div_load  = (state_reg == ST_LOAD);
        lane_ctrl.div_step  = (state_reg == ST_DIV);
    end

    // history flag as it stands once this row is counted
    assign history_flag = wrapped_reg || (row_reg == ROW_W'(HISTORY_ROWS - 1));

    always_comb
    begin
        feature_word = '0;
        for (int c = 0; c < LANES; c++)
        begin
            feature_word[(3*c)*FIELD_W   +: FIELD_W] = f_mean[c];
            feature_word[(3*c+1)*FIELD_W +: FIELD_W] = f_max[c];
            feature_word[(3*c+2)*FIELD_W +: FIELD_W] = f_min[c];
        end
        feature_word[3*LANES*FIELD_W +: ROW_OUT_W] = ROW_OUT_W'(row_reg);
        feature_word[3*LANES*FIELD_W + ROW_OUT_W]  = history_flag;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        wp_next       = wp_reg;
        full_next     = full_reg;
        row_next      = row_reg;
        wrapped_next  = wrapped_reg;
        nf_next       = nf_reg;
        rd_valid_next = 1'b0;
        rd_first_next = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        wr_en      = 1'b0;
        wr_addr    = wp_reg;
        wr_lane_en = lane_mask;
        wr_data    = sample_data;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // the row update happens in the finishing cycle of a full-window result
        // only, when the result is handed to the output register
        if (state_reg == ST_FINISH && !nf_reg && (!m_tvalid_reg || m_tready))
        begin
            if (row_reg == ROW_W'(HISTORY_ROWS - 1))
            begin
                row_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = cnt_reg;
                wr_lane_en = '1;
                wr_data    = '0;
                if (cnt_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser == KIND_SAMPLE)
                    begin
                        wr_en = 1'b1;
                        if (wp_reg == AW'(WINDOW_DEPTH - 1))
                        begin
                            wp_next   = '0;
                            full_next = 1'b1;
                        end
                        else
                        begin
                            wp_next = wp_reg + 1'b1;
                        end
                    end
                    else if (full_reg)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        nf_next    = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                rd_first_next = (cnt_reg == '0);
                if (cnt_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                // last read word goes into the lanes this cycle
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (nf_reg)
                    begin
                        m_tdata_next = '0;
                        m_tuser_next = STATUS_NOT_FULL;
                    end
                    else
                    begin
                        m_tdata_next = feature_word;
                        m_tuser_next = STATUS_VALID;
                    end
                    nf_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            row_reg      <= '0;
            wrapped_reg  <= 1'b0;
            nf_reg       <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            wp_reg       <= wp_next;
            full_reg     <= full_next;
            row_reg      <= row_next;
            wrapped_reg  <= wrapped_next;
            nf_reg       <= nf_next;
            rd_valid_reg <= rd_valid_next;
            rd_first_reg <= rd_first_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> bench/tb_windowed_min_max_mean_features_unit.sv
// ----------------------------------------------------------------------------
// tb_windowed_min_max_mean_features_unit
// self-checking bench for the windowed min / max / mean feature unit
// ----------------------------------------------------------------------------
// sample and compute words go in on the input stream. each accepted word
// updates a local copy of the sample ring and row counter. a compute word
// queues the feature word it should produce. every output word is checked
// field by field against the oldest queued feature word. the run covers the
// not-full window, the wrap boundary, windows of extreme values, a long
// receiver hold-off and random traffic with and without idle cycles.
// ----------------------------------------------------------------------------
module tb_windowed_min_max_mean_features_unit
    import wmm_pkg::*;
    ();

    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, defaults of the unit
    localparam int WINDOW_DEPTH = 120;
    localparam int HISTORY_ROWS = 180;
    localparam int CHANNELS     = 3;
    localparam int SAMPLE_BITS  = 16;

    // output word layout: mean, max, min per lane, then row and wrap flag
    localparam int LANE_STRIDE = 3 * FIELD_W;
    localparam int ROW_LSB     = LANES * LANE_STRIDE;
    localparam int WRAP_BIT    = ROW_LSB + ROW_OUT_W;

    // timing budget
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 150;   // one full scan plus divider and margin
    localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up

    typedef logic [LANES-1:0][FIELD_W-1:0] lanes_t;

    // one feature word as seen on m_tuser / m_tdata
    typedef struct packed {
        logic                         status;
        lanes_t                       mean;
        lanes_t                       hi;
        lanes_t                       lo;
        logic [ROW_OUT_W-1:0]         row;
        logic                         history_full;
    } features_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = KIND_SAMPLE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // local copy of the block state
    logic signed [FIELD_W-1:0] sample_ring [WINDOW_DEPTH][LANES];
    int                        ring_ptr;
    bit                        window_filled;
    int                        next_row;
    bit                        rows_wrapped;

    // feature words still to come out, oldest first
    features_t pending_features [$];

    // run control and bookkeeping
    bit    idle_enable  = 1'b1;
    bit    hold_request = 1'b0;
    int    error_count;
    int    words_sent;
    int    valid_results;
    int    not_full_results;
    int    history_wraps;
    string lane_name [LANES] = '{"voltage", "cell_temp", "ambient"};

    always #1 clk = ~clk;

    windowed_min_max_mean_features_unit #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .HISTORY_ROWS (HISTORY_ROWS),
        .CHANNELS     (CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // window tracking: a sample word updates the ring, a compute word queues
    // the feature word the block should return
    // ------------------------------------------------------------------------
    function automatic void apply_word_to_window(input logic kind, input lanes_t smp,
                                                 input logic [1:0] count);
        features_t                 f;
        longint                    sum;
        logic signed [FIELD_W-1:0] lo;
        logic signed [FIELD_W-1:0] hi;
        logic signed [FIELD_W-1:0] v;
        if (kind == KIND_SAMPLE)
        begin
            // count never exceeds the lane count, so no clamp is needed here
            for (int l = 0; l < LANES; l++)
            begin
                if (l < count)
                    sample_ring[ring_ptr][l] = smp[l];
            end
            ring_ptr++;
            if (ring_ptr == WINDOW_DEPTH)
            begin
                ring_ptr      = 0;
                window_filled = 1'b1;
            end
            return;
        end
        f = '0;
        if (!window_filled)
        begin
            // not full: status only, row counter stays put
            f.status = STATUS_NOT_FULL;
            not_full_results++;
        end
        else
        begin
            f.status = STATUS_VALID;
            for (int l = 0; l < LANES; l++)
            begin
                sum = 0;
                lo  = sample_ring[0][l];
                hi  = sample_ring[0][l];
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    v = sample_ring[i][l];
                    sum += v;
                    if (v < lo)
                        lo = v;
                    if (v > hi)
                        hi = v;
                end
                // signed division truncates toward zero
                f.mean[l] = FIELD_W'(sum / WINDOW_DEPTH);
                f.hi[l]   = hi;
                f.lo[l]   = lo;
            end
            // row is the counter value before the increment
            f.row = ROW_OUT_W'(next_row);
            next_row++;
            if (next_row == HISTORY_ROWS)
            begin
                next_row     = 0;
                rows_wrapped = 1'b1;
                history_wraps++;
            end
            f.history_full = rows_wrapped;
            valid_results++;
        end
        pending_features.push_back(f);
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // mostly random values, with a fair share of the extremes
    function automatic logic [FIELD_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic lanes_t pick_lanes();
        lanes_t smp;
        for (int l = 0; l < LANES; l++)
            smp[l] = pick_sample();
        return smp;
    endfunction

    // ------------------------------------------------------------------------
    // sender: one word per call, with an optional idle burst in front
    // ------------------------------------------------------------------------
    task automatic send_word(input logic kind, input lanes_t smp, input logic [1:0] count);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - LANES * FIELD_W - 2){1'b0}}, count, smp};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        apply_word_to_window(kind, smp, count);
    endtask

    task automatic send_sample(input lanes_t smp, input logic [1:0] count);
        send_word(KIND_SAMPLE, smp, count);
    endtask

    // sample fields of a compute word are ignored, so they carry noise
    task automatic send_compute();
        send_word(KIND_COMPUTE, lanes_t'({$urandom, $urandom}), 2'($urandom));
    endtask

    // drop valid, wait for every feature word, then let the scan settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_features.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // compute words before the ring has wrapped, samples at the field extremes
    task automatic test_window_not_full();
        send_compute();
        send_sample({16'h7fff, 16'h7fff, 16'h7fff}, 2'd3);
        send_sample({16'h8000, 16'h8000, 16'h8000}, 2'd3);
        send_sample({16'haaaa, 16'h5555, 16'hffff}, 2'd3);
        send_sample({16'h5555, 16'haaaa, 16'h0000}, 2'd2);
        send_compute();
        send_sample({16'h1234, 16'h8000, 16'h7fff}, 2'd1);
        // zero channels: pointer moves, nothing written
        send_sample({16'h7fff, 16'h7fff, 16'h7fff}, 2'd0);
        send_sample(pick_lanes(), 2'd0);
        send_compute();
        wait_drained();
    endtask

    // fill up to one short of the wrap, then step across it
    task automatic test_window_boundary();
        while (ring_ptr != WINDOW_DEPTH - 1)
            send_sample(pick_lanes(), 2'd3);
        send_compute();
        send_sample(pick_lanes(), 2'd3);
        send_compute();
        wait_drained();
    endtask

    // whole windows at the top and bottom of the range, and mean truncation
    task automatic test_extreme_windows();
        repeat (WINDOW_DEPTH) send_sample({16'h7fff, 16'h7fff, 16'h7fff}, 2'd3);
        send_compute();
        repeat (WINDOW_DEPTH) send_sample({16'h8000, 16'h8000, 16'h8000}, 2'd3);
        send_compute();
        // one -1 among zeros: the mean truncates to zero, not -1
        send_sample({16'h0, 16'h0, 16'hffff}, 2'd1);
        repeat (WINDOW_DEPTH - 1) send_sample({16'h7fff, 16'h7fff, 16'h0}, 2'd1);
        send_compute();
        wait_drained();
    endtask

    // mostly samples with full-width writes, a quarter compute words
    task automatic test_random_traffic(input int words);
        logic [1:0] count;
        repeat (words)
        begin
            if ($urandom_range(0, 3) == 0)
                send_compute();
            else
            begin
                count = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd3;
                send_sample(pick_lanes(), count);
            end
        end
        wait_drained();
    endtask

    // receiver holds off: the result register stays full, samples still go
    // in, and the next compute word stalls the input
    task automatic test_receiver_hold_off();
        hold_request = 1'b1;
        send_compute();
        repeat (20) send_sample(pick_lanes(), 2'd3);
        send_compute();
        repeat (5) send_sample(pick_lanes(), 2'd3);
        send_compute();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        features_t got;
        features_t want;
        int        stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                for (int l = 0; l < LANES; l++)
                begin
                    got.mean[l] = m_tdata[l * LANE_STRIDE +: FIELD_W];
                    got.hi[l]   = m_tdata[l * LANE_STRIDE + FIELD_W +: FIELD_W];
                    got.lo[l]   = m_tdata[l * LANE_STRIDE + 2 * FIELD_W +: FIELD_W];
                end
                got.row          = m_tdata[ROW_LSB +: ROW_OUT_W];
                got.history_full = m_tdata[WRAP_BIT];
                if (pending_features.size() == 0)
                begin
                    $error("feature word with none expected");
                    error_count++;
                end
                else
                begin
                    want = pending_features.pop_front();
                    compare_field("status", want.status, got.status);
                    for (int l = 0; l < LANES; l++)
                    begin
                        compare_field({lane_name[l], "_mean"},
                                      $signed(want.mean[l]), $signed(got.mean[l]));
                        compare_field({lane_name[l], "_max"},
                                      $signed(want.hi[l]), $signed(got.hi[l]));
                        compare_field({lane_name[l], "_min"},
                                      $signed(want.lo[l]), $signed(got.lo[l]));
                    end
                    compare_field("feature_row", want.row, got.row);
                    compare_field("history_full", want.history_full, got.history_full);
                end
            end
            // long hold-off wins over the short random stalls
            if (hold_request)
            begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too many cycles without any word moving ends the run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        // ring is cleared by reset, and so is the local copy
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            for (int l = 0; l < LANES; l++)
                sample_ring[i][l] = '0;
        end
        ring_ptr      = 0;
        window_filled = 1'b0;
        next_row      = 0;
        rows_wrapped  = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_window_not_full();
        test_window_boundary();
        test_extreme_windows();
        test_random_traffic(500);
        test_receiver_hold_off();
        test_random_traffic(500);
        // last stretch with no idle cycles on either side
        idle_enable = 1'b0;
        test_random_traffic(250);

        $display("sent %0d words: %0d valid feature words, %0d not-full words",
                 words_sent, valid_results, not_full_results);
        $display("history counter wrapped %0d times, %0d mismatches",
                 history_wraps, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
